>>> src/tfr_pkg.sv
// Shared types, codes and scaling helpers for the texel format expander.
// No dependencies; imported by every other file of the block.
package tfr_pkg;

   localparam int WordWidth = 32;
   localparam int ChanWidth = 8;
   localparam int TintWidth = 9;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 9;

   localparam logic [TintWidth-1:0] TintOne = 9'd256;

   typedef enum logic [2:0] {
      FMT_RGBA32   = 3'd0,
      FMT_RGBA5551 = 3'd1,
      FMT_IA16     = 3'd2,
      FMT_IA8      = 3'd3,
      FMT_IA4      = 3'd4,
      FMT_I8       = 3'd5,
      FMT_I4       = 3'd6,
      FMT_PALETTE  = 3'd7
   } fmt_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FORMAT     = 3'd0,
      CSR_RAW_LOAD   = 3'd1,
      CSR_TINT_RED   = 3'd2,
      CSR_TINT_GREEN = 3'd3,
      CSR_TINT_BLUE  = 3'd4,
      CSR_TINT_ALPHA = 3'd5
   } csr_index_type;

   typedef struct packed {
      fmt_type                fmt;
      logic                   raw_load;
      logic [TintWidth-1:0]   tint_red;
      logic [TintWidth-1:0]   tint_green;
      logic [TintWidth-1:0]   tint_blue;
      logic [TintWidth-1:0]   tint_alpha;
   } cfg_type;

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
      logic [ChanWidth-1:0] alpha;
      logic                 unsupported;
      logic                 last_of_item;
      logic                 last_of_image;
   } pix_type;

   // f*255/31 rounded down: 8f plus floor(7f/31), the latter by reciprocal
   function automatic logic [7:0] scale5(input logic [4:0] f);
      logic [7:0]  x;
      logic [16:0] p;
      x = 8'({3'b000, f} * 8'd7);
      p = 17'({9'd0, x} * 17'd265);
      return 8'({f, 3'b000} + {5'd0, p[15:13]});
   endfunction

   // i*255/7 rounded down: 36i plus floor(3i/7), the latter by reciprocal
   function automatic logic [7:0] scale3(input logic [2:0] i);
      logic [4:0] y;
      logic [9:0] p;
      y = 5'({2'b00, i} * 5'd3);
      p = 10'({5'd0, y} * 10'd37);
      return 8'({5'd0, i} * 8'd36 + {6'd0, p[9:8]});
   endfunction

endpackage

>>> src/tfr_csr.sv
// Configuration register file: format, raw-load flag and four tint factors.
// Depends on tfr_pkg.
module tfr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tfr_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [tfr_pkg::CsrDataWidth-1:0]    csr_wdata,
   output tfr_pkg::cfg_type                    cfg
);
   import tfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_FORMAT:     cfg_in.fmt = fmt_type'(csr_wdata[2:0]);
            CSR_RAW_LOAD:   cfg_in.raw_load = csr_wdata[0];
            CSR_TINT_RED:   cfg_in.tint_red = csr_wdata;
            CSR_TINT_GREEN: cfg_in.tint_green = csr_wdata;
            CSR_TINT_BLUE:  cfg_in.tint_blue = csr_wdata;
            CSR_TINT_ALPHA: cfg_in.tint_alpha = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fmt        <= FMT_RGBA32;
         cfg_ff.raw_load   <= 1'b0;
         cfg_ff.tint_red   <= TintOne;
         cfg_ff.tint_green <= TintOne;
         cfg_ff.tint_blue  <= TintOne;
         cfg_ff.tint_alpha <= TintOne;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/tfr_expand.sv
// Format decode: unpacks one pixel of a held word into 8-bit RGBA channels.
// Depends on tfr_pkg.
module tfr_expand (
   input  tfr_pkg::cfg_type                 cfg,
   input  logic [tfr_pkg::WordWidth-1:0]    word,
   input  logic                             last_word,
   input  logic                             sel,
   output tfr_pkg::pix_type                 pix
);
   import tfr_pkg::*;

   logic [7:0] hi;
   logic [7:0] lo;
   logic [3:0] nib;
   logic [7:0] nib17;
   logic [7:0] ia4_i;
   logic [7:0] ia4_a;
   logic       two_pixel;

   assign hi = word[15:8];
   assign lo = word[7:0];
   // high nibble first
   assign nib = sel ? lo[3:0] : lo[7:4];
   assign nib17 = {nib, nib};
   assign ia4_i = scale3(nib[3:1]);
   assign ia4_a = {8{nib[0]}};

   assign two_pixel = !cfg.raw_load && (cfg.fmt inside {FMT_IA4, FMT_I4});

   always_comb begin
      pix.unsupported   = 1'b0;
      pix.last_of_item  = !two_pixel || sel;
      pix.red   = word[31:24];
      pix.green = word[23:16];
      pix.blue  = word[15:8];
      pix.alpha = word[7:0];
      if (cfg.fmt == FMT_PALETTE) begin
         pix.red = '0;
         pix.green = '0;
         pix.blue = '0;
         pix.alpha = '0;
         pix.unsupported = 1'b1;
         pix.last_of_item = 1'b1;
      end else if (!cfg.raw_load) begin
         case (cfg.fmt)
            FMT_RGBA5551: begin
               pix.red   = scale5(hi[7:3]);
               pix.green = scale5({hi[2:0], lo[7:6]});
               pix.blue  = scale5(lo[5:1]);
               pix.alpha = {8{lo[0]}};
            end
            FMT_IA16: begin
               pix.red = hi;
               pix.green = hi;
               pix.blue = hi;
               pix.alpha = lo;
            end
            FMT_IA8: begin
               pix.red = {lo[7:4], lo[7:4]};
               pix.green = {lo[7:4], lo[7:4]};
               pix.blue = {lo[7:4], lo[7:4]};
               pix.alpha = {lo[3:0], lo[3:0]};
            end
            FMT_IA4: begin
               pix.red = ia4_i;
               pix.green = ia4_i;
               pix.blue = ia4_i;
               pix.alpha = ia4_a;
            end
            FMT_I8: begin
               pix.red = lo;
               pix.green = lo;
               pix.blue = lo;
               pix.alpha = lo;
            end
            FMT_I4: begin
               pix.red = nib17;
               pix.green = nib17;
               pix.blue = nib17;
               pix.alpha = nib17;
            end
            default: begin
               pix.red = word[31:24];
            end
         endcase
      end
      pix.last_of_image = pix.last_of_item && last_word;
   end

endmodule

>>> src/tfr_tint.sv
// Tint stage: multiplies each channel by its Q1.8 factor and saturates.
// Depends on tfr_pkg.
module tfr_tint (
   input  tfr_pkg::cfg_type  cfg,
   input  tfr_pkg::pix_type  pix_in,
   output tfr_pkg::pix_type  pix_out
);
   import tfr_pkg::*;

   function automatic logic [ChanWidth-1:0] tint(input logic [ChanWidth-1:0] v,
                                                 input logic [TintWidth-1:0] t);
      logic [ChanWidth+TintWidth-1:0] p;
      p = (ChanWidth+TintWidth)'({{TintWidth{1'b0}}, v} * {{ChanWidth{1'b0}}, t});
      return p[ChanWidth+TintWidth-1] ? {ChanWidth{1'b1}} : p[ChanWidth+TintWidth-2:8];
   endfunction

   always_comb begin
      pix_out = pix_in;
      pix_out.red   = tint(pix_in.red, cfg.tint_red);
      pix_out.green = tint(pix_in.green, cfg.tint_green);
      pix_out.blue  = tint(pix_in.blue, cfg.tint_blue);
      pix_out.alpha = tint(pix_in.alpha, cfg.tint_alpha);
   end

endmodule

>>> src/texel_format_to_rgba8_core.sv
// Texel format expander with tint. Each accepted word is held in an input
// register and turned into RGBA8888 pixels by one combinational pass that
// lands in the result register. Outside raw load, 4bpp formats (IA4, I4) give
// two pixels per word, high nibble first, and hold the input register until
// the second pixel goes; else a word gives one pixel and is taken every cycle
// unless the result side stalls. Throughput is set by the single result
// register: one pixel per cycle while rsp_ready is high. Pixels pass the
// input register, then the result register. Configuration writes take effect
// at once and are meant to happen only while idle.
// Depends on tfr_pkg, tfr_csr, tfr_expand and tfr_tint.
module texel_format_to_rgba8_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tfr_pkg::WordWidth-1:0]       req_texel_word,
   input  logic                                req_last_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tfr_pkg::ChanWidth-1:0]       rsp_red,
   output logic [tfr_pkg::ChanWidth-1:0]       rsp_green,
   output logic [tfr_pkg::ChanWidth-1:0]       rsp_blue,
   output logic [tfr_pkg::ChanWidth-1:0]       rsp_alpha,
   output logic                                rsp_unsupported,
   output logic                                rsp_last_of_item,
   output logic                                rsp_last_of_image,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tfr_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [tfr_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import tfr_pkg::*;

   cfg_type cfg;

   logic                 s1_valid_ff, s1_valid_in;
   logic [WordWidth-1:0] s1_word_ff, s1_word_in;
   logic                 s1_last_ff, s1_last_in;
   logic                 s1_sel_ff, s1_sel_in;
   logic                 out_valid_ff, out_valid_in;
   pix_type              out_pix_ff, out_pix_in;

   pix_type pix_raw;
   pix_type pix_tinted;
   logic    advance;
   logic    word_done;
   logic    req_fire;

   tfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tfr_expand u_expand (
      .cfg       (cfg),
      .word      (s1_word_ff),
      .last_word (s1_last_ff),
      .sel       (s1_sel_ff),
      .pix       (pix_raw)
   );

   tfr_tint u_tint (
      .cfg     (cfg),
      .pix_in  (pix_raw),
      .pix_out (pix_tinted)
   );

   // advance a pixel whenever the result register is free or being drained
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign word_done = advance && pix_raw.last_of_item;
   assign req_ready = !s1_valid_ff || word_done;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      s1_last_in  = s1_last_ff;
      s1_sel_in   = s1_sel_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_word_in  = req_texel_word;
         s1_last_in  = req_last_word;
         s1_sel_in   = 1'b0;
      end else if (word_done) begin
         s1_valid_in = 1'b0;
      end else if (advance) begin
         // first nibble sent; hold the word for the second
         s1_sel_in = 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_pix_in   = out_pix_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_pix_in   = pix_tinted;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_sel_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s1_sel_ff    <= s1_sel_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff <= s1_word_in;
      s1_last_ff <= s1_last_in;
      out_pix_ff <= out_pix_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_red           = out_pix_ff.red;
   assign rsp_green         = out_pix_ff.green;
   assign rsp_blue          = out_pix_ff.blue;
   assign rsp_alpha         = out_pix_ff.alpha;
   assign rsp_unsupported   = out_pix_ff.unsupported;
   assign rsp_last_of_item  = out_pix_ff.last_of_item;
   assign rsp_last_of_image = out_pix_ff.last_of_image;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for texel_format_to_rgba8_core: drives texel words and register writes,
// predicts each tinted RGBA pixel and checks every result beat. Depends on tfr_pkg.
module tb;
   import tfr_pkg::*;

   localparam int StallLimit   = 2000;
   localparam int RandomTarget = 1150;
   localparam int SteadyWords  = 150;
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_HI = 3'd7;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [WordWidth-1:0]       req_texel_word = '0;
   logic                       req_last_word = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [ChanWidth-1:0]       rsp_red, rsp_green, rsp_blue, rsp_alpha;
   logic                       rsp_unsupported, rsp_last_of_item, rsp_last_of_image;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CsrIndexWidth-1:0]   csr_index = '0;
   logic [CsrDataWidth-1:0]    csr_wdata = '0;

   texel_format_to_rgba8_core dut (.*);

   cfg_type    tex_cfg;
   pix_type    pixels_due[$];
   int         err_count = 0;
   int         words_sent = 0;
   int         pixels_checked = 0;
   int         regs_written = 0;
   int         gap_pct = 0;
   int         stall_pct = 0;
   int         stall_left = 0;
   int         quiet_cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // channel value times Q1.8 tint, clipped to 255
   function automatic logic [7:0] tinted(input logic [7:0] v, input logic [8:0] t);
      logic [16:0] prod;
      prod = ({9'd0, v} * {8'd0, t}) >> 8;
      return (prod > 17'd255) ? 8'hFF : prod[7:0];
   endfunction

   // stretch an n-bit field with maximum fmax to 0..255, rounded down
   function automatic logic [7:0] widen(input int unsigned f, input int unsigned fmax);
      return 8'((f * 255) / fmax);
   endfunction

   function automatic void push_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic [7:0] a,
                                      input logic end_item, input logic lastw);
      pix_type px;
      px.red           = tinted(r, tex_cfg.tint_red);
      px.green         = tinted(g, tex_cfg.tint_green);
      px.blue          = tinted(b, tex_cfg.tint_blue);
      px.alpha         = tinted(a, tex_cfg.tint_alpha);
      px.unsupported   = 1'b0;
      px.last_of_item  = end_item;
      px.last_of_image = end_item & lastw;
      pixels_due.insert(pixels_due.size(), px);
   endfunction

   function automatic void expand_word(input logic [31:0] w, input logic lastw);
      logic [7:0] hi, lo, c;
      pix_type    px;
      hi = w[15:8];
      lo = w[7:0];
      if (tex_cfg.fmt == FMT_PALETTE) begin
         px = '0;
         px.unsupported   = 1'b1;
         px.last_of_item  = 1'b1;
         px.last_of_image = lastw;
         pixels_due.insert(pixels_due.size(), px);
      end else if (tex_cfg.raw_load || tex_cfg.fmt == FMT_RGBA32) begin
         push_pixel(w[31:24], w[23:16], w[15:8], w[7:0], 1'b1, lastw);
      end else begin
         case (tex_cfg.fmt)
            FMT_RGBA5551: begin
               push_pixel(widen(32'(hi[7:3]), 31), widen(32'({hi[2:0], lo[7:6]}), 31),
                          widen(32'(lo[5:1]), 31), widen(32'(lo[0]), 1), 1'b1, lastw);
            end
            FMT_IA16: push_pixel(hi, hi, hi, lo, 1'b1, lastw);
            FMT_IA8: begin
               c = widen(32'(lo[7:4]), 15);
               push_pixel(c, c, c, widen(32'(lo[3:0]), 15), 1'b1, lastw);
            end
            FMT_IA4: begin
               c = widen(32'(lo[7:5]), 7);
               push_pixel(c, c, c, widen(32'(lo[4]), 1), 1'b0, lastw);
               c = widen(32'(lo[3:1]), 7);
               push_pixel(c, c, c, widen(32'(lo[0]), 1), 1'b1, lastw);
            end
            FMT_I8: push_pixel(lo, lo, lo, lo, 1'b1, lastw);
            FMT_I4: begin
               c = widen(32'(lo[7:4]), 15);
               push_pixel(c, c, c, c, 1'b0, lastw);
               c = widen(32'(lo[3:0]), 15);
               push_pixel(c, c, c, c, 1'b1, lastw);
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         err_count++;
      end
   endfunction

   // register shadow, expectation store and result check, all on one edge
   always @(posedge clock) begin : monitor
      pix_type want;
      if (reset) begin
         tex_cfg = '{fmt: FMT_RGBA32, raw_load: 1'b0, tint_red: TintOne,
                     tint_green: TintOne, tint_blue: TintOne, tint_alpha: TintOne};
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FORMAT:     tex_cfg.fmt = fmt_type'(csr_wdata[2:0]);
               CSR_RAW_LOAD:   tex_cfg.raw_load = csr_wdata[0];
               CSR_TINT_RED:   tex_cfg.tint_red = csr_wdata;
               CSR_TINT_GREEN: tex_cfg.tint_green = csr_wdata;
               CSR_TINT_BLUE:  tex_cfg.tint_blue = csr_wdata;
               CSR_TINT_ALPHA: tex_cfg.tint_alpha = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expand_word(req_texel_word, req_last_word);
         if (rsp_valid && rsp_ready) begin
            if (pixels_due.size() == 0) begin
               $error("pixel beat with nothing expected");
               err_count++;
            end else begin
               want = pixels_due.pop_front();
               check_field("red", 32'(want.red), 32'(rsp_red));
               check_field("green", 32'(want.green), 32'(rsp_green));
               check_field("blue", 32'(want.blue), 32'(rsp_blue));
               check_field("alpha", 32'(want.alpha), 32'(rsp_alpha));
               check_field("unsupported", 32'(want.unsupported), 32'(rsp_unsupported));
               check_field("last_of_item", 32'(want.last_of_item),
                           32'(rsp_last_of_item));
               check_field("last_of_image", 32'(want.last_of_image),
                           32'(rsp_last_of_image));
               pixels_checked++;
            end
         end
      end
   end

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_pct == 0) begin
         rsp_ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 11);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
         $display("stalled for %0d cycles with %0d pixels outstanding",
                  quiet_cycles, pixels_due.size());
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_word(input logic [31:0] word, input logic lastw);
      int gap;
      gap = 0;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
         gap = $urandom_range(1, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_texel_word <= word;
      req_last_word  <= lastw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // drop valid and hold until every expected pixel has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixels_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      regs_written++;
   endtask

   // upper data bits of the narrow registers carry noise
   task automatic set_config(input fmt_type fmt, input logic raw,
                             input logic [8:0] tr, input logic [8:0] tg,
                             input logic [8:0] tb, input logic [8:0] ta,
                             input logic with_spare);
      write_reg(CSR_FORMAT, {6'($urandom), fmt});
      write_reg(CSR_RAW_LOAD, {8'($urandom), raw});
      write_reg(CSR_TINT_RED, tr);
      write_reg(CSR_TINT_GREEN, tg);
      write_reg(CSR_TINT_BLUE, tb);
      write_reg(CSR_TINT_ALPHA, ta);
      if (with_spare) begin
         write_reg(CSR_SPARE_LO, 9'($urandom));
         write_reg(CSR_SPARE_HI, 9'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [8:0] tint_pick();
      case ($urandom_range(0, 3))
         0: return 9'd0;
         1: return TintOne;
         2: return 9'd511;
         default: return 9'($urandom_range(0, 511));
      endcase
   endfunction

   task automatic pick_idling();
      case ($urandom_range(0, 2))
         0: begin gap_pct = 0;  stall_pct = 0;  end
         1: begin gap_pct = 10; stall_pct = 5;  end
         default: begin gap_pct = 35; stall_pct = 20; end
      endcase
   endtask

   task automatic test_reset_state();
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h8040_2010, 1'b1);
      wait_idle();
   endtask

   task automatic test_each_format();
      fmt_type fmt;
      for (int f = 0; f < 8; f++) begin
         fmt = fmt_type'(f);
         set_config(fmt, 1'b0, TintOne, TintOne, TintOne, TintOne, 1'b0);
         send_word(32'hFFFF_FFFF, 1'b1);
         send_word(32'h5A5A_A53C, 1'b0);
         wait_idle();
      end
   endtask

   task automatic test_raw_load();
      set_config(FMT_IA4, 1'b1, TintOne, TintOne, TintOne, TintOne, 1'b0);
      send_word(32'h1234_5678, 1'b1);
      wait_idle();
      // palette stays unsupported even in raw mode
      set_config(FMT_PALETTE, 1'b1, TintOne, TintOne, TintOne, TintOne, 1'b0);
      send_word(32'hDEAD_BEEF, 1'b1);
      wait_idle();
   endtask

   task automatic test_tint_extremes();
      set_config(FMT_RGBA32, 1'b0, 9'd511, 9'd511, 9'd511, 9'd511, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h8080_8080, 1'b1);
      wait_idle();
      set_config(FMT_RGBA32, 1'b0, 9'd0, 9'd0, 9'd0, 9'd0, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      wait_idle();
   endtask

   task automatic test_spare_index();
      set_config(FMT_I4, 1'b0, 9'd128, 9'd300, TintOne, 9'd1, 1'b1);
      send_word(32'h0000_00F7, 1'b1);
      wait_idle();
   endtask

   task automatic test_random_phases();
      int count;
      while (words_sent < RandomTarget) begin
         pick_idling();
         set_config(fmt_type'($urandom_range(0, 7)), ($urandom_range(0, 3) == 0),
                    tint_pick(), tint_pick(), tint_pick(), tint_pick(),
                    ($urandom_range(0, 3) == 0));
         count = $urandom_range(30, 90);
         repeat (count) send_word($urandom, ($urandom_range(0, 7) == 0));
         wait_idle();
      end
   endtask

   task automatic test_steady_stream();
      gap_pct   = 0;
      stall_pct = 0;
      set_config(fmt_type'($urandom_range(0, 7)), 1'b0, tint_pick(), tint_pick(),
                 tint_pick(), tint_pick(), 1'b0);
      repeat (SteadyWords) send_word($urandom, ($urandom_range(0, 7) == 0));
      wait_idle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_each_format();
      test_raw_load();
      test_tint_extremes();
      test_spare_index();
      test_random_phases();
      test_steady_stream();
      repeat (8) @(posedge clock);
      if (pixels_due.size() != 0) begin
         $error("%0d expected pixels never arrived", pixels_due.size());
         err_count++;
      end
      $display("covered all eight format codes, raw mode, tint 0..511 and spare indexes:");
      $display("%0d words in, %0d pixels checked, %0d register writes, %0d errors",
               words_sent, pixels_checked, regs_written, err_count);
      if (err_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> filelist.f
src/tfr_pkg.sv
src/tfr_csr.sv
src/tfr_expand.sv
src/tfr_tint.sv
src/texel_format_to_rgba8_core.sv
tb/sv/tb.sv
